FILE: hw/rtl/mmd_pkg.sv
// Shared constants and types for the matrix product dot engine.
`default_nettype none

package mmd_pkg;

	// Matrix store geometry
	localparam int MAX_DIM = 16;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W  = 2 * IDX_W;

	// Element and sum widths (Q8.8 in, Q20.16 out)
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 36;

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

	// Operation codes on the input word
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
	localparam logic [OP_W-1:0] OP_REQ  = 2'd2;

	// Command queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Classified command kinds
	typedef enum logic [1:0] {
		K_WR_A = 2'd0,
		K_WR_B = 2'd1,
		K_REQ  = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
		logic [DIM_W-1:0]  inner;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mmd_front.sv
// Front end: configuration registers, word accept and command classification.
`default_nettype none

module mmd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mmd_pkg::OP_W-1:0]     operation,
	input  wire logic [mmd_pkg::IDX_W-1:0]    row,
	input  wire logic [mmd_pkg::IDX_W-1:0]    col,
	input  wire logic [mmd_pkg::ELEM_W-1:0]   value,
	input  wire logic                         cfg_we,
	input  wire logic [mmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [mmd_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                         q_full,
	output logic                              busy,
	output logic                              push,
	output mmd_pkg::cmd_t                     push_cmd
);
	import mmd_pkg::*;

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] inner_q;
	logic [CFG_W-1:0] cols_q;
	logic [DIM_W-1:0] m_eff;
	logic [DIM_W-1:0] k_eff;
	logic [DIM_W-1:0] n_eff;
	logic             accept;
	logic             in_range;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_W'(MAX_DIM);
			inner_q <= CFG_W'(MAX_DIM);
			cols_q  <= CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROWS:  rows_q  <= cfg_wdata;
				CFG_INNER: inner_q <= cfg_wdata;
				CFG_COLS:  cols_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp sizes at the store dimension
	assign m_eff = (rows_q  > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(rows_q);
	assign k_eff = (inner_q > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(inner_q);
	assign n_eff = (cols_q  > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cols_q);

	assign in_range = (DIM_W'(row) < m_eff) && (DIM_W'(col) < n_eff);

	// Accept a word while the queue has room
	assign busy   = q_full;
	assign accept = start && !q_full;

	// Classify the word; drop the unused code
	always_comb begin
		push_cmd.row   = row;
		push_cmd.col   = col;
		push_cmd.value = value;
		push_cmd.inner = k_eff;
		push_cmd.kind  = K_ERR;
		push           = 1'b0;
		unique case (operation)
			OP_WR_A: begin
				push_cmd.kind = K_WR_A;
				push          = accept;
			end
			OP_WR_B: begin
				push_cmd.kind = K_WR_B;
				push          = accept;
			end
			OP_REQ: begin
				push_cmd.kind = in_range ? K_REQ : K_ERR;
				push          = accept;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mmd_queue.sv
// Short command queue between the front end and the dot product unit.
`default_nettype none

module mmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mmd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               full,
	output logic               q_valid,
	output mmd_pkg::cmd_t      q_cmd
);
	import mmd_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	// Store the word at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mmd_back.sv
// Back end: matrix stores and the multiply-accumulate sequencer.
`default_nettype none

module mmd_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	input  wire mmd_pkg::cmd_t             q_cmd,
	output logic                           pop,
	output logic                           done,
	output logic [mmd_pkg::SUM_W-1:0]      dot_sum,
	output logic [mmd_pkg::IDX_W-1:0]      result_row,
	output logic [mmd_pkg::IDX_W-1:0]      result_col,
	output logic                           status
);
	import mmd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t                    state_q;
	logic [ELEM_W-1:0]         left_mem  [MAX_DIM*MAX_DIM];
	logic [ELEM_W-1:0]         right_mem [MAX_DIM*MAX_DIM];
	logic [ADDR_W-1:0]         a_addr;
	logic [ADDR_W-1:0]         b_addr;
	logic [ADDR_W-1:0]         wr_addr;
	logic signed [ELEM_W-1:0]  a_rd_s1;
	logic signed [ELEM_W-1:0]  b_rd_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [SUM_W-1:0]          prod_ext;
	logic [SUM_W-1:0]          acc_q;
	logic [IDX_W-1:0]          t_q;
	logic [IDX_W-1:0]          req_row_q;
	logic [IDX_W-1:0]          req_col_q;
	logic [DIM_W-1:0]          k_q;
	logic                      vld_s1;
	logic                      last_s1;
	logic                      vld_s2;
	logic                      last_s2;
	logic                      t_last;
	logic                      fin_mac;
	logic                      fin_now;
	logic                      done_q;
	logic [SUM_W-1:0]          dot_sum_q;
	logic [IDX_W-1:0]          row_out_q;
	logic [IDX_W-1:0]          col_out_q;
	logic                      status_q;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign wr_addr  = {q_cmd.row, q_cmd.col};
	assign a_addr   = {req_row_q, t_q};
	assign b_addr   = {t_q, req_col_q};
	assign t_last   = (DIM_W'(t_q) == k_q - DIM_W'(1));
	assign prod_ext = {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign fin_mac  = vld_s2 && last_s2;
	// Requests that finish without any inner term
	assign fin_now  = pop && ((q_cmd.kind == K_ERR) ||
		((q_cmd.kind == K_REQ) && (q_cmd.inner == '0)));

	// Write the element stores
	always_ff @(posedge clk) begin
		if (pop && (q_cmd.kind == K_WR_A)) begin
			left_mem[wr_addr] <= q_cmd.value;
		end
		if (pop && (q_cmd.kind == K_WR_B)) begin
			right_mem[wr_addr] <= q_cmd.value;
		end
	end

	// Read one A and one B element per cycle
	always_ff @(posedge clk) begin
		a_rd_s1 <= left_mem[a_addr];
		b_rd_s1 <= right_mem[b_addr];
	end

	// Multiply, then accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (pop) begin
			acc_q     <= '0;
			req_row_q <= q_cmd.row;
			req_col_q <= q_cmd.col;
			k_q       <= q_cmd.inner;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// Sequence the inner terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			t_q     <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			unique case (state_q)
				ST_IDLE: begin
					t_q <= '0;
					if (pop && (q_cmd.kind == K_REQ) && (q_cmd.inner != '0)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					vld_s1  <= 1'b1;
					last_s1 <= t_last;
					t_q     <= t_q + 1'b1;
					if (t_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (fin_mac) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Strobe the result word for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_mac || fin_now;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (fin_mac) begin
			dot_sum_q <= acc_q + prod_ext;
			row_out_q <= req_row_q;
			col_out_q <= req_col_q;
			status_q  <= 1'b0;
		end else if (fin_now) begin
			dot_sum_q <= '0;
			row_out_q <= q_cmd.row;
			col_out_q <= q_cmd.col;
			status_q  <= (q_cmd.kind == K_ERR);
		end
	end

	assign done       = done_q;
	assign dot_sum    = dot_sum_q;
	assign result_row = row_out_q;
	assign result_col = col_out_q;
	assign status     = status_q;

	a_read_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_RUN))
		else $error("element read issued outside the run state");

	a_mult_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("product stage valid without a read");

	a_err_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q) |-> (dot_sum_q == '0))
		else $error("error result carries a nonzero sum");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2) |-> !pop)
		else $error("queue popped while terms are in flight");

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_multiply_dot_engine.sv
// Top level of the matrix product dot engine: front end, queue and MAC unit.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   command  | start / busy        | operation, row, col, value
//   result   | done (1-cycle)      | dot_sum, result_row, result_col, status
//   config   | cfg_we              | cfg_idx, cfg_wdata
//
// A word is taken when start is high and busy is low; it enters a two-entry
// command queue. Element writes retire as soon as the MAC unit pops them. A
// product request in range makes one store read per inner term, then passes
// the multiply and add stages; an error or k of zero retires when popped.
// busy rises only when the queue is full. The receiver cannot stall: done is
// high for exactly one cycle per result. Reset clears control and sets all
// three size registers to 16; the element stores hold no reset value.
`default_nettype none

module matrix_multiply_dot_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [mmd_pkg::OP_W-1:0]      operation,
	input  wire logic [mmd_pkg::IDX_W-1:0]     row,
	input  wire logic [mmd_pkg::IDX_W-1:0]     col,
	input  wire logic [mmd_pkg::ELEM_W-1:0]    value,
	output logic                               done,
	output logic [mmd_pkg::SUM_W-1:0]          dot_sum,
	output logic [mmd_pkg::IDX_W-1:0]          result_row,
	output logic [mmd_pkg::IDX_W-1:0]          result_col,
	output logic                               status,
	input  wire logic                          cfg_we,
	input  wire logic [mmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [mmd_pkg::CFG_W-1:0]     cfg_wdata
);
	import mmd_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	mmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.row       (row),
		.col       (col),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	mmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	mmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.pop        (pop),
		.done       (done),
		.dot_sum    (dot_sum),
		.result_row (result_row),
		.result_col (result_col),
		.status     (status)
	);

endmodule

`default_nettype wire

FILE: tb/matrix_multiply_dot_engine_test.sv
// Self-checking testbench for the matrix product dot engine: random and directed words.
module matrix_multiply_dot_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mmd_pkg::*;

	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;
	localparam logic                 ST_OK     = 1'b0;
	localparam logic                 ST_RANGE  = 1'b1;
	localparam int                   SETTLE    = 40;
	localparam int                   RANDOM_WORDS = 850;

	typedef enum logic [1:0] {
		E_CMD,
		E_CFG,
		E_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t          kind;
		logic [OP_W-1:0]      op;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic [ELEM_W-1:0]    value;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
	} pending_t;

	typedef struct {
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             stat;
	} product_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [OP_W-1:0]      operation = '0;
	logic [IDX_W-1:0]     row       = '0;
	logic [IDX_W-1:0]     col       = '0;
	logic [ELEM_W-1:0]    value     = '0;
	logic                 done;
	logic [SUM_W-1:0]     dot_sum;
	logic [IDX_W-1:0]     result_row;
	logic [IDX_W-1:0]     result_col;
	logic                 status;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Words waiting to be driven and products waiting to come back
	pending_t word_queue[$];
	product_t product_queue[$];
	int       errors = 0;

	// Predictor copy of the stores and the size registers
	logic [ELEM_W-1:0] left_store[MAX_DIM*MAX_DIM];
	logic [ELEM_W-1:0] right_store[MAX_DIM*MAX_DIM];
	logic [CFG_W-1:0]  size_rows  = 5'd16;
	logic [CFG_W-1:0]  size_inner = 5'd16;
	logic [CFG_W-1:0]  size_cols  = 5'd16;

	// Generator view: sizes in force and which elements hold a value
	logic [CFG_W-1:0] plan_rows  = 5'd16;
	logic [CFG_W-1:0] plan_inner = 5'd16;
	logic [CFG_W-1:0] plan_cols  = 5'd16;
	bit               have_a[MAX_DIM*MAX_DIM];
	bit               have_b[MAX_DIM*MAX_DIM];
	int               words_made = 0;

	int gap_left    = 0;
	int quiet       = 0;
	int steady_left = 0;

	matrix_multiply_dot_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.row        (row),
		.col        (col),
		.value      (value),
		.done       (done),
		.dot_sum    (dot_sum),
		.result_row (result_row),
		.result_col (result_col),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	// Clock and reset
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic int size_eff(input logic [CFG_W-1:0] reg_val);
		return (reg_val > MAX_DIM) ? MAX_DIM : int'(reg_val);
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one or a steady stretch
	function automatic int pick_gap();
		int r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 3)
			steady_left = $urandom_range(30, 100);
		if (r < 100)
			return 0;
		if (r < 170)
			return $urandom_range(1, 3);
		if (r < 195)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ELEM_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Expected product for one request under the sizes in force
	function automatic product_t dot_of(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		product_t p;
		longint   acc;
		int       m;
		int       k;
		int       n;
		logic [IDX_W-1:0] t4;
		m = size_eff(size_rows);
		k = size_eff(size_inner);
		n = size_eff(size_cols);
		acc = 0;
		p.row = r;
		p.col = c;
		if (r >= m || c >= n) begin
			p.stat = ST_RANGE;
		end else begin
			p.stat = ST_OK;
			for (int t = 0; t < k; t++) begin
				t4 = IDX_W'(t);
				acc += longint'($signed(left_store[{r, t4}])) *
					longint'($signed(right_store[{t4, c}]));
			end
		end
		p.sum = acc[SUM_W-1:0];
		return p;
	endfunction

	// Apply one accepted word to the predictor
	task automatic predict_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
		case (op)
			OP_WR_A: left_store[{r, c}] = v;
			OP_WR_B: right_store[{r, c}] = v;
			OP_REQ:  product_queue.push_back(dot_of(r, c));
			default: ;
		endcase
	endtask

	task automatic apply_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			CFG_ROWS:  size_rows = data;
			CFG_INNER: size_inner = data;
			CFG_COLS:  size_cols = data;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Stimulus builders
	task automatic push_cmd(input logic [OP_W-1:0] op, input int r, input int c,
			input logic [ELEM_W-1:0] v);
		pending_t e;
		e.kind = E_CMD;
		e.op = op;
		e.row = IDX_W'(r);
		e.col = IDX_W'(c);
		e.value = v;
		e.idx = '0;
		e.data = '0;
		word_queue.push_back(e);
		if (op == OP_WR_A)
			have_a[r*MAX_DIM + c] = 1'b1;
		if (op == OP_WR_B)
			have_b[r*MAX_DIM + c] = 1'b1;
		if (op != OP_UNUSED)
			words_made++;
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		pending_t e;
		e.kind = E_CFG;
		e.op = '0;
		e.row = '0;
		e.col = '0;
		e.value = '0;
		e.idx = idx;
		e.data = data;
		word_queue.push_back(e);
		case (idx)
			CFG_ROWS:  plan_rows = data;
			CFG_INNER: plan_inner = data;
			CFG_COLS:  plan_cols = data;
			default: ;
		endcase
	endtask

	task automatic push_drain();
		pending_t e;
		e.kind = E_DRAIN;
		e.op = '0;
		e.row = '0;
		e.col = '0;
		e.value = '0;
		e.idx = '0;
		e.data = '0;
		word_queue.push_back(e);
	endtask

	// Request one product; write first any element it reads that never got a value
	task automatic push_req(input int r, input int c);
		int m;
		int k;
		int n;
		m = size_eff(plan_rows);
		k = size_eff(plan_inner);
		n = size_eff(plan_cols);
		if (r < m && c < n) begin
			for (int t = 0; t < k; t++) begin
				if (!have_a[r*MAX_DIM + t])
					push_cmd(OP_WR_A, r, t, pick_value());
				if (!have_b[t*MAX_DIM + c])
					push_cmd(OP_WR_B, t, c, pick_value());
			end
		end
		push_cmd(OP_REQ, r, c, ELEM_W'($urandom));
	endtask

	function automatic logic [CFG_W-1:0] pick_size(input bit allow_zero);
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return CFG_W'($urandom_range(17, 31));
		if (r < 4)
			return 5'd1;
		if (r < 6)
			return 5'd16;
		if (r == 6 && allow_zero)
			return 5'd0;
		return CFG_W'($urandom_range(1, 16));
	endfunction

	task automatic build_directed();
		push_cfg(CFG_INNER, 5'd2);
		// Most negative and most positive elements
		push_cmd(OP_WR_A, 0, 0, 16'h8000);
		push_cmd(OP_WR_A, 0, 1, 16'h8000);
		push_cmd(OP_WR_B, 0, 0, 16'h8000);
		push_cmd(OP_WR_B, 1, 0, 16'h8000);
		push_cmd(OP_WR_A, 15, 0, 16'h7FFF);
		push_cmd(OP_WR_A, 15, 1, 16'h8000);
		push_cmd(OP_WR_B, 0, 15, 16'h7FFF);
		push_cmd(OP_WR_B, 1, 15, 16'h7FFF);
		push_req(0, 0);
		push_req(15, 15);
		push_req(0, 15);
		push_req(15, 0);
		// Unused operation code and unused register index: both ignored
		push_cmd(OP_UNUSED, 15, 15, 16'hFFFF);
		push_cfg(CFG_NONE, 5'd31);
		push_req(15, 15);
		// Inner size of zero: zero sum, status ok
		push_cfg(CFG_INNER, 5'd0);
		push_req(3, 7);
		// Row count of zero: every request out of range
		push_cfg(CFG_ROWS, 5'd0);
		push_req(0, 0);
		// One column, one inner term
		push_cfg(CFG_ROWS, 5'd16);
		push_cfg(CFG_COLS, 5'd1);
		push_cfg(CFG_INNER, 5'd1);
		push_req(0, 0);
		push_req(0, 1);
		push_req(15, 0);
		push_cmd(OP_WR_A, 0, 0, 16'h0000);
		push_req(0, 0);
	endtask

	task automatic build_random();
		int phase;
		int phase_end;
		int r;
		int m;
		int n;
		bit drained;
		phase = 0;
		drained = 1'b0;
		words_made = 0;
		while (words_made < RANDOM_WORDS) begin
			// New sizes: all above the limit first, then all one, then random
			if (phase == 0) begin
				push_cfg(CFG_ROWS, 5'd31);
				push_cfg(CFG_INNER, 5'd31);
				push_cfg(CFG_COLS, 5'd31);
			end else if (phase == 1) begin
				push_cfg(CFG_ROWS, 5'd1);
				push_cfg(CFG_INNER, 5'd1);
				push_cfg(CFG_COLS, 5'd1);
			end else begin
				if ($urandom_range(0, 3) != 0)
					push_cfg(CFG_ROWS, pick_size(1'b0));
				if ($urandom_range(0, 3) != 0)
					push_cfg(CFG_INNER, pick_size(1'b1));
				if ($urandom_range(0, 3) != 0)
					push_cfg(CFG_COLS, pick_size(1'b0));
			end
			phase_end = words_made + $urandom_range(60, 160);
			while (words_made < phase_end && words_made < RANDOM_WORDS) begin
				m = size_eff(plan_rows);
				n = size_eff(plan_cols);
				r = $urandom_range(0, 99);
				if (r < 45)
					push_req($urandom_range(0, m - 1), $urandom_range(0, n - 1));
				else if (r < 55)
					push_req($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1));
				else if (r < 93)
					push_cmd(($urandom_range(0, 1) != 0) ? OP_WR_B : OP_WR_A,
						$urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
						pick_value());
				else
					push_cmd(OP_UNUSED, $urandom_range(0, MAX_DIM - 1),
						$urandom_range(0, MAX_DIM - 1), ELEM_W'($urandom));
				// Hold off once mid-run until every product is back
				if (!drained && words_made > RANDOM_WORDS / 2) begin
					push_drain();
					drained = 1'b1;
				end
			end
			phase++;
		end
	endtask

	// Driver: present words on start/busy, write sizes only when the engine is idle
	always @(posedge clk or negedge arst_n) begin : drive
		logic took;
		logic settled;
		logic nx_start;
		logic nx_we;
		if (!arst_n) begin
			start <= 1'b0;
			operation <= '0;
			row <= '0;
			col <= '0;
			value <= '0;
			cfg_we <= 1'b0;
			cfg_idx <= '0;
			cfg_wdata <= '0;
			gap_left <= 0;
			quiet <= 0;
		end else begin
			took = start && !busy;
			if (took) begin
				predict_word(operation, row, col, value);
				quiet <= 0;
			end else if (quiet < SETTLE) begin
				quiet <= quiet + 1;
			end
			settled = !took && (product_queue.size() == 0) && (quiet >= SETTLE);
			nx_start = 1'b0;
			nx_we = 1'b0;
			if (start && busy) begin
				nx_start = 1'b1;
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (word_queue.size() != 0) begin
				case (word_queue[0].kind)
					E_CMD: begin
						nx_start = 1'b1;
						operation <= word_queue[0].op;
						row <= word_queue[0].row;
						col <= word_queue[0].col;
						value <= word_queue[0].value;
						gap_left <= pick_gap();
						void'(word_queue.pop_front());
					end
					E_CFG: begin
						if (settled) begin
							nx_we = 1'b1;
							cfg_idx <= word_queue[0].idx;
							cfg_wdata <= word_queue[0].data;
							apply_size(word_queue[0].idx, word_queue[0].data);
							void'(word_queue.pop_front());
						end
					end
					default: begin
						if (settled)
							void'(word_queue.pop_front());
					end
				endcase
			end
			start <= nx_start;
			cfg_we <= nx_we;
		end
	end

	// Monitor: compare each product against the oldest expectation
	always @(posedge clk) begin : watch
		product_t want;
		if (arst_n && done) begin
			if (product_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected product row %0d col %0d",
					result_row, result_col));
			end else begin
				want = product_queue.pop_front();
				if (dot_sum !== want.sum)
					report_mismatch($sformatf("C(%0d,%0d) dot_sum %h, want %h",
						want.row, want.col, dot_sum, want.sum));
				if (result_row !== want.row)
					report_mismatch($sformatf("result_row %0d, want %0d",
						result_row, want.row));
				if (result_col !== want.col)
					report_mismatch($sformatf("result_col %0d, want %0d",
						result_col, want.col));
				if (status !== want.stat)
					report_mismatch($sformatf("C(%0d,%0d) status %0b, want %0b",
						want.row, want.col, status, want.stat));
			end
		end
	end

	// Build the stimulus, wait for the engine to drain, then judge
	initial begin
		build_directed();
		build_random();
		@(posedge clk);
		while (!arst_n || word_queue.size() != 0 || start || product_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && product_queue.size() == 0) begin
			$display("matrix_multiply_dot_engine test passed");
		end else begin
			$display("matrix_multiply_dot_engine test failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("matrix_multiply_dot_engine test failed");
		$finish;
	end

endmodule
